[sv/grf_pkg.sv]
// Shared types, command codes and default sizes for the grid rectangle fill block.
`timescale 1ns / 1ps
`default_nettype none

package grf_pkg;

    localparam int COORD_W = 6;
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 2;

    localparam int DEF_GRID_ROWS  = 64;
    localparam int DEF_GRID_COLS  = 64;
    localparam int DEF_CELL_WIDTH = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [COORD_W-1:0]        row_first;
        logic [COORD_W-1:0]        col_first;
        logic [COORD_W-1:0]        row_last;
        logic [COORD_W-1:0]        col_last;
        logic signed [DATA_W-1:0]  value;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0]  read_value;
        logic                      status;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic latch;     // capture an accepted command
        logic step;      // write current cell, advance walk
        logic res_load;  // load result into output register
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic err;       // coordinate outside grid
        logic wr_cmd;    // load or fill
        logic empty;     // rectangle has no cells
        logic col_end;   // walk at last column
        logic row_end;   // walk at last row
    } t_sts;

endpackage

`default_nettype wire

[sv/grid_rectangle_fill.sv]
// Top level of the grid rectangle fill block: controller plus datapath.
// Sequence: a read, an error or an unused code passes through accept, execute and
// result; an error-free load or fill also walks its rectangle between execute and
// result, one cell written per cycle on the single memory write port. One command at a time.
// Reset: synchronous active low; clears controller state and output valid only.
// Cell memory is not cleared, a cell is defined once it has been written.
`timescale 1ns / 1ps
`default_nettype none

module grid_rectangle_fill
    import grf_pkg::*;
#(
    parameter int GRID_ROWS  = DEF_GRID_ROWS,
    parameter int GRID_COLS  = DEF_GRID_COLS,
    parameter int CELL_WIDTH = DEF_CELL_WIDTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // command channel
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    // result channel
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    // command/status between the state machine and the datapath
    t_ctl ctl;
    t_sts sts;

    // Controller: idle -> execute -> (fill walk) -> result. The input side is ready
    // only in idle; the output register lets a new transfer in while the previous
    // result still waits on the output channel.
    grf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    // Datapath: bounds check at accept, row/column walk, cell memory with
    // registered read, result register.
    grf_datapath #(
        .GRID_ROWS  (GRID_ROWS),
        .GRID_COLS  (GRID_COLS),
        .CELL_WIDTH (CELL_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_in_data  (i_in_data),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

[sv/grf_ctrl.sv]
// Controller state machine for the grid rectangle fill block.
`timescale 1ns / 1ps
`default_nettype none

module grf_ctrl
    import grf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_ctl      o_ctl
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_FILL   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_ctl.latch    = 1'b0;
        o_ctl.step     = 1'b0;
        o_ctl.res_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_sts.err && i_sts.wr_cmd && !i_sts.empty) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_FILL: begin
                o_ctl.step = 1'b1;
                if (i_sts.col_end && i_sts.row_end) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctl.res_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[sv/grf_datapath.sv]
// Datapath: command registers, rectangle walk counters, cell memory, result register.
`timescale 1ns / 1ps
`default_nettype none

module grf_datapath
    import grf_pkg::*;
#(
    parameter int GRID_ROWS  = DEF_GRID_ROWS,
    parameter int GRID_COLS  = DEF_GRID_COLS,
    parameter int CELL_WIDTH = DEF_CELL_WIDTH
) (
    input  wire logic i_clk,
    input  wire t_in  i_in_data,
    input  wire t_ctl i_ctl,
    output t_sts      o_sts,
    output t_out      o_out_data
);

    localparam int          DEPTH  = GRID_ROWS * GRID_COLS;
    localparam int          AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [31:0] ROWS_U = 32'(GRID_ROWS);
    localparam logic [31:0] COLS_U = 32'(GRID_COLS);

    logic [CELL_WIDTH-1:0] r_mem [DEPTH];
    logic [CELL_WIDTH-1:0] r_rd_data;

    logic [CMD_W-1:0]      r_cmd;
    logic                  r_err;
    logic [COORD_W-1:0]    r_row;
    logic [COORD_W-1:0]    r_col;
    logic [COORD_W-1:0]    r_col_first;
    logic [COORD_W-1:0]    r_row_last;
    logic [COORD_W-1:0]    r_col_last;
    logic [CELL_WIDTH-1:0] r_value;
    t_out                  r_out;

    logic                  n_err;
    logic                  first_ok;
    logic                  last_ok;
    logic                  is_fill;
    logic [AW-1:0]         addr;

    assign is_fill  = (i_in_data.cmd == CMD_FILL);
    assign first_ok = (32'(i_in_data.row_first) < ROWS_U)
                   && (32'(i_in_data.col_first) < COLS_U);
    assign last_ok  = (32'(i_in_data.row_last) < ROWS_U)
                   && (32'(i_in_data.col_last) < COLS_U);

    always_comb begin
        case (i_in_data.cmd)
            CMD_LOAD, CMD_READ: n_err = !first_ok;
            CMD_FILL:           n_err = !(first_ok && last_ok);
            default:            n_err = 1'b0;
        endcase
    end

    // row-major cell address
    assign addr = AW'(32'(r_row) * COLS_U + 32'(r_col));

    assign o_sts.err     = r_err;
    assign o_sts.wr_cmd  = (r_cmd == CMD_LOAD) || (r_cmd == CMD_FILL);
    assign o_sts.empty   = (r_row > r_row_last) || (r_col > r_col_last);
    assign o_sts.col_end = (r_col == r_col_last);
    assign o_sts.row_end = (r_row == r_row_last);

    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd       <= i_in_data.cmd;
            r_err       <= n_err;
            r_row       <= i_in_data.row_first;
            r_col       <= i_in_data.col_first;
            r_col_first <= i_in_data.col_first;
            // a load is a one-cell rectangle
            r_row_last  <= is_fill ? i_in_data.row_last : i_in_data.row_first;
            r_col_last  <= is_fill ? i_in_data.col_last : i_in_data.col_first;
            r_value     <= CELL_WIDTH'(i_in_data.value);
        end else if (i_ctl.step) begin
            if (o_sts.col_end) begin
                r_col <= r_col_first;
                if (!o_sts.row_end) begin
                    r_row <= COORD_W'(r_row + 1'b1);
                end
            end else begin
                r_col <= COORD_W'(r_col + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_mem[addr] <= r_value;
        end
        r_rd_data <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.res_load) begin
            r_out.status     <= r_err;
            r_out.read_value <= (r_cmd == CMD_READ && !r_err) ? DATA_W'(r_rd_data)
                                                              : '0;
        end
    end

endmodule

`default_nettype wire

[test/grf_result_checker.sv]
// Result checker for the grid rectangle fill block: tracks grid contents and checks every result.
`timescale 1ns / 1ps
`default_nettype none

module grf_result_checker
    import grf_pkg::*;
#(
    parameter int GRID_ROWS  = DEF_GRID_ROWS,
    parameter int GRID_COLS  = DEF_GRID_COLS,
    parameter int CELL_WIDTH = DEF_CELL_WIDTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_ready,
    input  wire t_in  i_in_data,
    input  wire logic i_out_valid,
    input  wire logic i_out_ready,
    input  wire t_out i_out_data,
    output int        o_fail_count,
    output int        o_result_count
);

    localparam int SHOWN_MISMATCHES = 10;

    // shadow copy of the cell array, kept at the block's cell width
    logic [CELL_WIDTH-1:0] shadow_cells [GRID_ROWS*GRID_COLS];
    t_out                  pending_answers [$];
    int                    fail_total   = 0;
    int                    result_total = 0;

    function automatic logic on_grid(int row, int col);
        return row < GRID_ROWS && col < GRID_COLS;
    endfunction

    // apply one command to the shadow grid and return the answer it earns
    function automatic t_out apply_command(t_in c);
        t_out        answer;
        logic [63:0] wide;
        logic [63:0] held;
        int          r0;
        int          c0;
        int          r1;
        int          c1;
        answer = '0;
        r0     = int'(c.row_first);
        c0     = int'(c.col_first);
        r1     = int'(c.row_last);
        c1     = int'(c.col_last);
        wide   = {{32{c.value[DATA_W-1]}}, c.value};
        case (c.cmd)
            CMD_LOAD: begin
                if (on_grid(r0, c0))
                    shadow_cells[r0*GRID_COLS + c0] = wide[CELL_WIDTH-1:0];
                else
                    answer.status = 1'b1;
            end
            CMD_FILL: begin
                // both corners are checked before anything is written
                if (on_grid(r0, c0) && on_grid(r1, c1)) begin
                    for (int r = r0; r <= r1; r++)
                        for (int col = c0; col <= c1; col++)
                            shadow_cells[r*GRID_COLS + col] = wide[CELL_WIDTH-1:0];
                end else begin
                    answer.status = 1'b1;
                end
            end
            CMD_READ: begin
                if (on_grid(r0, c0)) begin
                    held              = 64'(shadow_cells[r0*GRID_COLS + c0]);
                    answer.read_value = held[DATA_W-1:0];
                end else begin
                    answer.status = 1'b1;
                end
            end
            default: ;
        endcase
        return answer;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            // results first: a result never belongs to a command taken at the same edge
            if (i_out_valid && i_out_ready) begin
                result_total++;
                if (pending_answers.size() == 0) begin
                    fail_total++;
                    if (fail_total <= SHOWN_MISMATCHES)
                        $display("checker: unexpected result value=%h status=%b",
                                 i_out_data.read_value, i_out_data.status);
                end else begin
                    want = pending_answers.pop_front();
                    if (want.read_value !== i_out_data.read_value ||
                            want.status !== i_out_data.status) begin
                        fail_total++;
                        if (fail_total <= SHOWN_MISMATCHES)
                            $display({"checker: result %0d expected value=%h status=%b,",
                                      " got value=%h status=%b"},
                                     result_total, want.read_value, want.status,
                                     i_out_data.read_value, i_out_data.status);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                pending_answers = {pending_answers, apply_command(i_in_data)};
        end
        o_fail_count   <= fail_total;
        o_result_count <= result_total;
    end

endmodule

`default_nettype wire

[test/tb_grid_rectangle_fill.sv]
// Testbench top for the grid rectangle fill block: stimulus, flow control and verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb_grid_rectangle_fill;
    import grf_pkg::*;

    localparam int               MAX_COORD    = 63;
    localparam int               RANDOM_ITEMS = 120;
    localparam int               QUIET_TAIL   = 30;    // last random items run with no idling
    localparam int               HOLD_AT      = 40;    // random item where the long hold starts
    localparam int               PAUSE_AT     = 90;    // random item where the sender drains
    localparam int               LONG_HOLD    = 300;   // receiver hold-off, in cycles
    localparam int               DRAIN_CYCLES = 16;
    // 141 commands, each at worst a whole-grid fill, plus worst-case gaps and stalls, taken several times over
    localparam int               RUN_LIMIT    = 3_000_000;
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic out_ready = 1'b0;
    t_in  in_data   = '0;
    logic in_ready;
    logic out_valid;
    t_out out_data;

    int   fail_count;
    int   result_count;
    int   sent_count   = 0;
    int   cycle_count  = 0;

    // shared between the sender and the receiver processes
    logic allow_idle   = 1'b1;
    logic hold_request = 1'b0;

    grid_rectangle_fill u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    grf_result_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .o_fail_count   (fail_count),
        .o_result_count (result_count)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic t_in make_cmd(logic [CMD_W-1:0] cmd, int r0, int c0, int r1, int c1,
                                     logic [DATA_W-1:0] value);
        t_in c;
        c.cmd       = cmd;
        c.row_first = COORD_W'(r0);
        c.col_first = COORD_W'(c0);
        c.row_last  = COORD_W'(r1);
        c.col_last  = COORD_W'(c1);
        c.value     = value;
        return c;
    endfunction

    // Random command mix: reads and loads anywhere, fills mostly small rectangles,
    // now and then a rectangle from fully random corners (often empty, sometimes huge),
    // and a few unused codes. The full-grid fill in the directed part has already
    // defined every cell, so reads may land anywhere.
    function automatic t_in random_cmd();
        t_in c;
        int  roll;
        int  span;
        c.cmd       = CMD_READ;
        c.row_first = COORD_W'($urandom_range(0, MAX_COORD));
        c.col_first = COORD_W'($urandom_range(0, MAX_COORD));
        c.row_last  = COORD_W'($urandom_range(0, MAX_COORD));
        c.col_last  = COORD_W'($urandom_range(0, MAX_COORD));
        c.value     = $urandom;
        roll        = $urandom_range(0, 99);
        if (roll < 40) begin
            c.cmd = CMD_READ;
        end else if (roll < 65) begin
            c.cmd = CMD_LOAD;
        end else if (roll < 95) begin
            c.cmd = CMD_FILL;
            if ($urandom_range(0, 19) != 0) begin
                // small rectangle of up to four rows and columns from the first corner, clipped at the grid edge
                span       = int'(c.row_first) + int'($urandom_range(0, 3));
                c.row_last = COORD_W'((span > MAX_COORD) ? MAX_COORD : span);
                span       = int'(c.col_first) + int'($urandom_range(0, 3));
                c.col_last = COORD_W'((span > MAX_COORD) ? MAX_COORD : span);
                // occasionally inverted so nothing is written
                if ($urandom_range(0, 9) == 0 && c.row_first != 0)
                    c.row_last = c.row_first - 1'b1;
            end
        end else begin
            c.cmd = CMD_UNUSED;
        end
        return c;
    endfunction

    // Offer one command and hold it until the transfer. Valid stays high straight
    // into the next command unless a gap is inserted.
    task automatic issue(input t_in item);
        int gap;
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_count++;
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request so that the
    // block backs up and stops taking commands.
    initial begin : result_sink
        int stall;
        wait (rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (allow_idle && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 12);
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < RUN_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Coordinates are 6 bits wide on a 64 x 64 grid, so an
        // off-grid coordinate cannot be formed at this size; the checker still models it.
        // Only the cell just loaded is read before the whole grid is filled.
        issue(make_cmd(CMD_LOAD, 0, 0, 0, 0, 32'h8000_0000));
        issue(make_cmd(CMD_READ, 0, 0, 0, 0, 32'h0));
        // whole grid: longest fill, and every cell defined from here on
        issue(make_cmd(CMD_FILL, 0, 0, MAX_COORD, MAX_COORD, 32'h7FFF_FFFF));
        issue(make_cmd(CMD_READ, MAX_COORD, MAX_COORD, 0, 0, 32'h0));
        issue(make_cmd(CMD_READ, 0, MAX_COORD, 0, 0, 32'h0));
        issue(make_cmd(CMD_LOAD, MAX_COORD, MAX_COORD, 0, 0, 32'hFFFF_FFFF));
        issue(make_cmd(CMD_READ, MAX_COORD, MAX_COORD, 0, 0, 32'h0));
        // single-cell rectangle
        issue(make_cmd(CMD_FILL, 5, 7, 5, 7, 32'h1234_5678));
        issue(make_cmd(CMD_READ, 5, 7, 0, 0, 32'h0));
        // empty rectangles: rows inverted, then columns inverted; nothing may change
        issue(make_cmd(CMD_FILL, 10, 0, 9, MAX_COORD, 32'hDEAD_BEEF));
        issue(make_cmd(CMD_READ, 10, 0, 0, 0, 32'h0));
        issue(make_cmd(CMD_FILL, 3, MAX_COORD, 3, 0, 32'hDEAD_BEEF));
        issue(make_cmd(CMD_READ, 3, 0, 0, 0, 32'h0));
        // unused command code with every field bit set
        issue(make_cmd(CMD_UNUSED, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, 32'hFFFF_FFFF));
        // one full row, one full column
        issue(make_cmd(CMD_FILL, 20, 0, 20, MAX_COORD, 32'h5555_5555));
        issue(make_cmd(CMD_READ, 20, MAX_COORD, 0, 0, 32'h0));
        issue(make_cmd(CMD_FILL, 0, 30, MAX_COORD, 30, 32'hAAAA_AAAA));
        issue(make_cmd(CMD_READ, MAX_COORD, 30, 0, 0, 32'h0));
        issue(make_cmd(CMD_LOAD, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, 32'h0));
        issue(make_cmd(CMD_READ, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, 32'h0));
        issue(make_cmd(CMD_READ, MAX_COORD, 0, 0, 0, 32'h0));

        // Random part.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == HOLD_AT)
                hold_request = 1'b1;           // receiver backs off, sender keeps offering
            if (k == PAUSE_AT) begin
                // drop valid so the last command is not offered again while draining
                in_valid <= 1'b0;
                wait (result_count == sent_count);
            end
            if (k == RANDOM_ITEMS - QUIET_TAIL)
                allow_idle = 1'b0;
            issue(random_cmd());
        end
        in_valid <= 1'b0;

        wait (result_count == sent_count);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
sv/grf_pkg.sv
sv/grf_ctrl.sv
sv/grf_datapath.sv
sv/grid_rectangle_fill.sv
test/grf_result_checker.sv
test/tb_grid_rectangle_fill.sv
